FILE: sv/fbik_pkg.sv
package fbik_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN      = 24;
  localparam int CORDIC_LEN    = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

  localparam int SQRT_CELLS = 18;
  localparam int SQRT_VW    = 36;
  localparam int SQRT_RW    = 22;
  localparam int SQRT_QW    = 18;

  localparam int DIV_CELLS = 15;
  localparam int DIV_RW    = 37;
  localparam int DIV_DW    = 36;

  localparam int CW    = 46;
  localparam int AW    = 34;
  localparam int SHW   = 5;
  localparam int LANES = 3;

  localparam logic signed [AW-1:0] HALF_PI_Q30 = 34'sd1686629713;

  typedef enum logic [1:0] {
    CFG_UPPER  = 2'd0,
    CFG_LOWER  = 2'd1,
    CFG_MIRROR = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic signed [17:0] foot_x;
    logic signed [17:0] foot_z;
    logic signed [37:0] num;
    logic signed [15:0] c;
    logic               unreach;
  } side_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] ang;
  } cvec_t;

  function automatic logic [AW-1:0] atan_entry(input int i);
    case (i)
      0:       return 34'd843314857;
      1:       return 34'd497837829;
      2:       return 34'd263043837;
      3:       return 34'd133525159;
      4:       return 34'd67021687;
      5:       return 34'd33543516;
      6:       return 34'd16775851;
      7:       return 34'd8388437;
      8:       return 34'd4194283;
      9:       return 34'd2097149;
      10:      return 34'd1048576;
      11:      return 34'd524288;
      12:      return 34'd262144;
      13:      return 34'd131072;
      14:      return 34'd65536;
      15:      return 34'd32768;
      16:      return 34'd16384;
      17:      return 34'd8192;
      18:      return 34'd4096;
      19:      return 34'd2048;
      20:      return 34'd1024;
      21:      return 34'd512;
      22:      return 34'd256;
      23:      return 34'd128;
      default: return '0;
    endcase
  endfunction

endpackage

FILE: sv/fbik_sqrt_cell.sv
module fbik_sqrt_cell import fbik_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid_in,
  input  logic [SQRT_VW-1:0] v_in,
  input  logic [SQRT_RW-1:0] rem_in,
  input  logic [SQRT_QW-1:0] q_in,
  input  side_t              side_in,
  output logic               valid_out,
  output logic [SQRT_VW-1:0] v_out,
  output logic [SQRT_RW-1:0] rem_out,
  output logic [SQRT_QW-1:0] q_out,
  output side_t              side_out
);

  logic [SQRT_RW-1:0] cur;
  logic [SQRT_RW-1:0] trial;
  logic               ge;

  assign cur   = {rem_in[SQRT_RW-3:0], v_in[SQRT_VW-1:SQRT_VW-2]};
  assign trial = {2'b00, q_in, 2'b01};
  assign ge    = cur >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
    v_out    <= {v_in[SQRT_VW-3:0], 2'b00};
    rem_out  <= ge ? cur - trial : cur;
    q_out    <= {q_in[SQRT_QW-2:0], ge};
    side_out <= side_in;
  end

endmodule

FILE: sv/fbik_div_cell.sv
module fbik_div_cell import fbik_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid_in,
  input  logic [DIV_RW-1:0]    rem_in,
  input  logic [DIV_DW-1:0]    den_in,
  input  logic [DIV_CELLS-1:0] q_in,
  input  side_t                side_in,
  output logic                 valid_out,
  output logic [DIV_RW-1:0]    rem_out,
  output logic [DIV_DW-1:0]    den_out,
  output logic [DIV_CELLS-1:0] q_out,
  output side_t                side_out
);

  logic              ge;
  logic [DIV_RW-1:0] diff;

  assign ge   = rem_in >= {1'b0, den_in};
  assign diff = ge ? rem_in - {1'b0, den_in} : rem_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
    rem_out  <= {diff[DIV_RW-2:0], 1'b0};
    den_out  <= den_in;
    q_out    <= {q_in[DIV_CELLS-2:0], ge};
    side_out <= side_in;
  end

endmodule

FILE: sv/fbik_cordic_cell.sv
module fbik_cordic_cell import fbik_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid_in,
  input  cvec_t [LANES-1:0]    vec_in,
  input  side_t                side_in,
  input  logic [SHW-1:0]       shift,
  input  logic signed [AW-1:0] step_angle,
  output logic                 valid_out,
  output cvec_t [LANES-1:0]    vec_out,
  output side_t                side_out
);

  cvec_t [LANES-1:0] vec_next;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (vec_in[l].y >= 0) begin
        vec_next[l].x   = vec_in[l].x + (vec_in[l].y >>> shift);
        vec_next[l].y   = vec_in[l].y - (vec_in[l].x >>> shift);
        vec_next[l].ang = vec_in[l].ang + step_angle;
      end else begin
        vec_next[l].x   = vec_in[l].x - (vec_in[l].y >>> shift);
        vec_next[l].y   = vec_in[l].y + (vec_in[l].x >>> shift);
        vec_next[l].ang = vec_in[l].ang - step_angle;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
    vec_out  <= vec_next;
    side_out <= side_in;
  end

endmodule

FILE: sv/fivebar_inverse_kinematics_top.sv
// Pipeline from the accepting edge to done: two 18-cell square-root chains,
//   a 15-cell divider chain and the CORDIC chain, plus eight single-stage
//   registers.
// Throughput: one word per cycle; busy is high only in reset and the receiver cannot stall.
// Reset clears all valid flags and loads the link lengths and mirror default.
module fivebar_inverse_kinematics_top import fbik_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [17:0]        foot_x,
  input  logic [17:0]        foot_z,
  output logic               done,
  output logic signed [17:0] joint_a_angle,
  output logic signed [17:0] joint_b_angle,
  output logic               unreachable,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [16:0]        cfg_wdata
);

  localparam int LATENCY = 8 + 2 * SQRT_CELLS + DIV_CELLS + CORDIC_LEN;

  logic [16:0] upper_link_length;
  logic [16:0] lower_link_length;
  logic        mirror_leg;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_link_length <= 17'd6554;
      lower_link_length <= 17'd13107;
      mirror_leg        <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_UPPER:  upper_link_length <= cfg_wdata;
        CFG_LOWER:  lower_link_length <= cfg_wdata;
        CFG_MIRROR: mirror_leg        <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign busy = rst;

  logic               s1_valid;
  logic signed [17:0] s1_x;
  logic signed [17:0] s1_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_x <= foot_x;
    s1_z <= foot_z;
  end

  logic signed [35:0] xx_full;
  logic signed [35:0] zz_full;
  logic               s2_valid;
  logic [34:0]        s2_xx;
  logic [34:0]        s2_zz;
  logic [33:0]        s2_l1sq;
  logic [33:0]        s2_l2sq;
  logic signed [17:0] s2_x;
  logic signed [17:0] s2_z;

  assign xx_full = s1_x * s1_x;
  assign zz_full = s1_z * s1_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_xx   <= xx_full[34:0];
    s2_zz   <= zz_full[34:0];
    s2_l1sq <= upper_link_length * upper_link_length;
    s2_l2sq <= lower_link_length * lower_link_length;
    s2_x    <= s1_x;
    s2_z    <= s1_z;
  end

  logic               s3_valid;
  logic [35:0]        s3_r2;
  side_t              s3_side;
  logic [35:0]        r2_sum;

  assign r2_sum = {1'b0, s2_xx} + {1'b0, s2_zz};

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_r2          <= r2_sum;
    s3_side.foot_x <= s2_x;
    s3_side.foot_z <= s2_z;
    s3_side.num    <= $signed({2'b00, r2_sum}) + $signed({4'b0000, s2_l1sq})
                      - $signed({4'b0000, s2_l2sq});
    s3_side.c      <= '0;
    s3_side.unreach <= 1'b0;
  end

  logic  [SQRT_CELLS:0]               sa_valid;
  logic  [SQRT_CELLS:0][SQRT_VW-1:0]  sa_v;
  logic  [SQRT_CELLS:0][SQRT_RW-1:0]  sa_rem;
  logic  [SQRT_CELLS:0][SQRT_QW-1:0]  sa_q;
  side_t [SQRT_CELLS:0]               sa_side;

  assign sa_valid[0] = s3_valid;
  assign sa_v[0]     = s3_r2;
  assign sa_rem[0]   = '0;
  assign sa_q[0]     = '0;
  assign sa_side[0]  = s3_side;

  for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt_a
    fbik_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (sa_valid[k]),
      .v_in      (sa_v[k]),
      .rem_in    (sa_rem[k]),
      .q_in      (sa_q[k]),
      .side_in   (sa_side[k]),
      .valid_out (sa_valid[k+1]),
      .v_out     (sa_v[k+1]),
      .rem_out   (sa_rem[k+1]),
      .q_out     (sa_q[k+1]),
      .side_out  (sa_side[k+1])
    );
  end

  logic        s4_valid;
  logic [35:0] s4_den;
  side_t       s4_side;
  logic [34:0] r_l1;

  assign r_l1 = sa_q[SQRT_CELLS] * upper_link_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= sa_valid[SQRT_CELLS];
    end
    s4_den  <= {r_l1, 1'b0};
    s4_side <= sa_side[SQRT_CELLS];
  end

  logic        s5_valid;
  logic [DIV_RW-1:0] s5_rem;
  logic [DIV_DW-1:0] s5_den;
  side_t       s5_side;
  side_t       s5_side_next;
  logic [37:0] anum;

  assign anum = s4_side.num[37] ? 38'(-s4_side.num) : s4_side.num;

  always_comb begin
    s5_side_next         = s4_side;
    s5_side_next.unreach = (s4_den == '0) || (anum > {2'b00, s4_den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
    s5_rem  <= anum[DIV_RW-1:0];
    s5_den  <= s4_den;
    s5_side <= s5_side_next;
  end

  logic  [DIV_CELLS:0]                 dv_valid;
  logic  [DIV_CELLS:0][DIV_RW-1:0]     dv_rem;
  logic  [DIV_CELLS:0][DIV_DW-1:0]     dv_den;
  logic  [DIV_CELLS:0][DIV_CELLS-1:0]  dv_q;
  side_t [DIV_CELLS:0]                 dv_side;

  assign dv_valid[0] = s5_valid;
  assign dv_rem[0]   = s5_rem;
  assign dv_den[0]   = s5_den;
  assign dv_q[0]     = '0;
  assign dv_side[0]  = s5_side;

  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
    fbik_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (dv_valid[k]),
      .rem_in    (dv_rem[k]),
      .den_in    (dv_den[k]),
      .q_in      (dv_q[k]),
      .side_in   (dv_side[k]),
      .valid_out (dv_valid[k+1]),
      .rem_out   (dv_rem[k+1]),
      .den_out   (dv_den[k+1]),
      .q_out     (dv_q[k+1]),
      .side_out  (dv_side[k+1])
    );
  end

  logic        s6_valid;
  logic [28:0] s6_v2;
  side_t       s6_side;
  side_t       s6_side_next;
  logic [29:0] qq;
  logic [15:0] q_ext;

  assign q_ext = {1'b0, dv_q[DIV_CELLS]};
  assign qq    = dv_q[DIV_CELLS] * dv_q[DIV_CELLS];

  always_comb begin
    s6_side_next   = dv_side[DIV_CELLS];
    s6_side_next.c = dv_side[DIV_CELLS].num[37] ? -q_ext : q_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else begin
      s6_valid <= dv_valid[DIV_CELLS];
    end
    s6_v2   <= 29'h1000_0000 - qq[28:0];
    s6_side <= s6_side_next;
  end

  logic  [SQRT_CELLS:0]               sb_valid;
  logic  [SQRT_CELLS:0][SQRT_VW-1:0]  sb_v;
  logic  [SQRT_CELLS:0][SQRT_RW-1:0]  sb_rem;
  logic  [SQRT_CELLS:0][SQRT_QW-1:0]  sb_q;
  side_t [SQRT_CELLS:0]               sb_side;

  assign sb_valid[0] = s6_valid;
  assign sb_v[0]     = {{(SQRT_VW-29){1'b0}}, s6_v2};
  assign sb_rem[0]   = '0;
  assign sb_q[0]     = '0;
  assign sb_side[0]  = s6_side;

  for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt_b
    fbik_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (sb_valid[k]),
      .v_in      (sb_v[k]),
      .rem_in    (sb_rem[k]),
      .q_in      (sb_q[k]),
      .side_in   (sb_side[k]),
      .valid_out (sb_valid[k+1]),
      .v_out     (sb_v[k+1]),
      .rem_out   (sb_rem[k+1]),
      .q_out     (sb_q[k+1]),
      .side_out  (sb_side[k+1])
    );
  end

  function automatic cvec_t prerot(input logic signed [CW-1:0] y,
                                   input logic signed [CW-1:0] x);
    cvec_t v;
    v.x   = x;
    v.y   = y;
    v.ang = '0;
    if (x < 0) begin
      if (y >= 0) begin
        v.x   = y;
        v.y   = -x;
        v.ang = HALF_PI_Q30;
      end else begin
        v.x   = -y;
        v.y   = x;
        v.ang = -HALF_PI_Q30;
      end
    end
    return v;
  endfunction

  side_t                sb_out;
  logic signed [CW-1:0] sc_s;
  logic signed [CW-1:0] sc_c;
  logic signed [CW-1:0] sc_x;
  logic signed [CW-1:0] sc_z;
  logic                 s7_valid;
  cvec_t [LANES-1:0]    s7_vec;
  side_t                s7_side;

  assign sb_out = sb_side[SQRT_CELLS];
  assign sc_s = {{(CW-SQRT_QW-24){1'b0}}, sb_q[SQRT_CELLS], 24'b0};
  assign sc_c = {{(CW-40){sb_out.c[15]}}, sb_out.c, 24'b0};
  assign sc_x = {{(CW-42){sb_out.foot_x[17]}}, sb_out.foot_x, 24'b0};
  assign sc_z = {{(CW-42){sb_out.foot_z[17]}}, sb_out.foot_z, 24'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else begin
      s7_valid <= sb_valid[SQRT_CELLS];
    end
    s7_vec[0] <= prerot(sc_s, sc_c);
    s7_vec[1] <= prerot(-sc_z, sc_x);
    s7_vec[2] <= prerot(-sc_z, -sc_x);
    s7_side   <= sb_out;
  end

  logic  [CORDIC_LEN:0]            cr_valid;
  cvec_t [CORDIC_LEN:0][LANES-1:0] cr_vec;
  side_t [CORDIC_LEN:0]            cr_side;

  assign cr_valid[0] = s7_valid;
  assign cr_vec[0]   = s7_vec;
  assign cr_side[0]  = s7_side;

  for (genvar k = 0; k < CORDIC_LEN; k++) begin : g_cordic
    fbik_cordic_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .valid_in   (cr_valid[k]),
      .vec_in     (cr_vec[k]),
      .side_in    (cr_side[k]),
      .shift      (SHW'(k)),
      .step_angle ($signed(atan_entry(k))),
      .valid_out  (cr_valid[k+1]),
      .vec_out    (cr_vec[k+1]),
      .side_out   (cr_side[k+1])
    );
  end

  logic signed [AW:0] d0;
  logic signed [AW:0] d1;
  logic signed [AW:0] r0;
  logic signed [AW:0] r1;
  logic [17:0]        a0;
  logic [17:0]        a1;

  assign d0 = cr_vec[CORDIC_LEN][1].ang - cr_vec[CORDIC_LEN][0].ang;
  assign d1 = cr_vec[CORDIC_LEN][2].ang - cr_vec[CORDIC_LEN][0].ang;
  assign r0 = d0 + 35'sd32768;
  assign r1 = d1 + 35'sd32768;
  assign a0 = mirror_leg ? 18'(-r0[33:16]) : r0[33:16];
  assign a1 = mirror_leg ? 18'(-r1[33:16]) : r1[33:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cr_valid[CORDIC_LEN];
    end
    unreachable   <= cr_side[CORDIC_LEN].unreach;
    joint_a_angle <= cr_side[CORDIC_LEN].unreach ? '0 : a0;
    joint_b_angle <= cr_side[CORDIC_LEN].unreach ? '0 : a1;
  end

  a_zero_when_unreachable: assert property (@(posedge clk) disable iff (rst)
    done && unreachable |-> joint_a_angle == 18'sd0 && joint_b_angle == 18'sd0)
    else $error("angles not zero on unreachable target");

  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("accepted word produced no result");

  a_latency_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without an accepted word");

endmodule
